FILE: rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps
package wsd_pkg;

	// Result kinds
	localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
	localparam logic [2:0] KIND_PING      = 3'd1;
	localparam logic [2:0] KIND_PONG      = 3'd2;
	localparam logic [2:0] KIND_CLOSE     = 3'd3;
	localparam logic [2:0] KIND_UNMASKED  = 3'd4;
	localparam logic [2:0] KIND_OVERSIZE  = 3'd5;
	localparam logic [2:0] KIND_PING_DUE  = 3'd6;
	localparam logic [2:0] KIND_PONG_TOUT = 3'd7;

	// Frame opcodes
	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;
	localparam logic [3:0] OP_PONG  = 4'd10;

	// Header fields
	localparam logic [7:0] HDR_FIN_MASK = 8'h80;
	localparam logic [7:0] HDR_OP_MASK  = 8'h0F;
	localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
	localparam logic [6:0] LEN_EXT16    = 7'd126;
	localparam logic [6:0] LEN_EXT64    = 7'd127;
	localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

	// Connection states
	localparam logic [1:0] CONN_OPEN   = 2'd0;
	localparam logic [1:0] CONN_CLOSED = 2'd2;
	localparam logic [1:0] CONN_ERROR  = 2'd3;

	// Configuration register indexes
	localparam int CFG_IW = 2;
	typedef logic [CFG_IW-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MAX_LEN   = 2'd0;
	localparam cfg_idx_t CFG_PING_INT  = 2'd1;
	localparam cfg_idx_t CFG_PONG_TOUT = 2'd2;

	localparam logic [31:0] MAX_LEN_RST   = 32'd1048576;
	localparam logic [15:0] PING_INT_RST  = 16'd30;
	localparam logic [15:0] PONG_TOUT_RST = 16'd10;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_KEY     = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic [3:0]  message_opcode;
		logic [3:0]  frame_opcode;
		logic        frame_end;
		logic        message_end;
		logic [15:0] close_code;
	} rec_t;

	// One accepted item's results: first, and optional second
	typedef struct packed {
		rec_t r0;
		rec_t r1;
		logic two;
	} entry_t;

endpackage

FILE: rtl/core/wsd_if.sv
`timescale 1ns / 1ps
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface wsd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic [3:0]  message_opcode;
	logic [3:0]  frame_opcode;
	logic        frame_end;
	logic        message_end;
	logic [15:0] close_code;
	logic        run_last;

	modport source (output valid, kind, payload_byte, message_opcode, frame_opcode,
		frame_end, message_end, close_code, run_last, input ready);
	modport sink (input valid, kind, payload_byte, message_opcode, frame_opcode,
		frame_end, message_end, close_code, run_last, output ready);
endinterface

FILE: rtl/core/websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// Channel   Dir   Carries                               Handshake
// items     in    action, data_byte                     valid/ready
// results   out   kind, payload_byte, opcodes, ends,    valid/ready
//                 close_code, run_last
// cfg       in    cfg_we, cfg_index, cfg_data           write on cfg_we
//
// One item is taken every cycle while the result queue is not full; the
// header, length check and unmasking of an item finish in the cycle it is accepted.
// An item with two results (last payload byte plus its control event, or
// ping due plus pong timeout) gives them on the result port one after the other.
// Reset is asynchronous and clears parser, timers and queue at once.
// items.ready drops only while the four-entry result queue is full.
module websocket_frame_deframer_top (
	input  logic              clk,
	input  logic              arst_n,
	wsd_in_if.sink            items,
	wsd_out_if.source         results,
	input  logic              cfg_we,
	input  wsd_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]       cfg_data
);
	import wsd_pkg::*;

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   head_valid;
	entry_t head;
	logic   pop;

	// Front end: parse each transaction and hold the connection state
	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple parser from result port stalls
	wsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Back end: advance through the results of each entry, one per transaction
	wsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule

FILE: rtl/core/wsd_front.sv
`timescale 1ns / 1ps
module wsd_front (
	input  logic             clk,
	input  logic             arst_n,
	wsd_in_if.sink           items,
	input  logic             cfg_we,
	input  wsd_pkg::cfg_idx_t cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             q_full,
	output logic             push,
	output wsd_pkg::entry_t  push_entry
);
	import wsd_pkg::*;

	logic [31:0] max_len_q;
	logic [15:0] ping_int_q, pong_to_q;

	phase_t      phase_q, phase_n;
	logic        fin_q, fin_n;
	logic [3:0]  fop_q, fop_n;
	logic [63:0] len_q, len_n;
	logic [2:0]  lenleft_q, lenleft_n;
	logic [31:0] key_q, key_n;
	logic [63:0] pleft_q, pleft_n;
	logic [1:0]  midx_q, midx_n;
	logic [15:0] ccode_q, ccode_n;
	logic [1:0]  cseen_q, cseen_n;
	logic [3:0]  mop_q, mop_n;
	logic        inmsg_q, inmsg_n;
	logic [1:0]  conn_q, conn_n;
	logic        await_q, await_n;
	logic [15:0] spong_q, spong_n;
	logic [15:0] sping_q, sping_n;

	logic        fire;
	logic        a_vld, b_vld;
	rec_t        a_rec, b_rec;
	logic        do_check, do_finish;
	logic [7:0]  b;
	logic [6:0]  l7;
	logic [31:0] key_sh;
	logic [7:0]  pb;
	logic        last;

	assign items.ready = !q_full;
	assign fire = items.valid && items.ready;
	assign b = items.data_byte;
	assign l7 = b[6:0] & HDR_LEN_MASK[6:0];
	assign key_sh = key_q >> {2'd3 - midx_q, 3'b000};
	assign pb = b ^ key_sh[7:0];

	always_comb begin
		phase_n = phase_q;
		fin_n = fin_q;
		fop_n = fop_q;
		len_n = len_q;
		lenleft_n = lenleft_q;
		key_n = key_q;
		pleft_n = pleft_q;
		midx_n = midx_q;
		ccode_n = ccode_q;
		cseen_n = cseen_q;
		mop_n = mop_q;
		inmsg_n = inmsg_q;
		conn_n = conn_q;
		await_n = await_q;
		spong_n = spong_q;
		sping_n = sping_q;
		a_vld = 1'b0;
		b_vld = 1'b0;
		a_rec = '0;
		b_rec = '0;
		do_check = 1'b0;
		do_finish = 1'b0;
		last = 1'b0;

		if (conn_q == CONN_OPEN && items.action) begin
			spong_n = (spong_q == 16'hFFFF) ? spong_q : spong_q + 16'd1;
			sping_n = (sping_q == 16'hFFFF) ? sping_q : sping_q + 16'd1;
			if (!await_q && spong_n >= ping_int_q) begin
				await_n = 1'b1;
				sping_n = '0;
				a_vld = 1'b1;
				a_rec.kind = KIND_PING_DUE;
			end
			if (await_n && sping_n >= pong_to_q) begin
				conn_n = CONN_CLOSED;
				b_vld = 1'b1;
				b_rec.kind = KIND_PONG_TOUT;
			end
		end else if (conn_q == CONN_OPEN) begin
			case (phase_q)
				PH_HDR1: begin
					if ((b & HDR_FIN_MASK) == 8'h00) begin
						conn_n = CONN_ERROR;
						a_vld = 1'b1;
						a_rec.kind = KIND_UNMASKED;
					end else if (l7 == LEN_EXT16 || l7 == LEN_EXT64) begin
						lenleft_n = (l7 == LEN_EXT16) ? 3'd1 : 3'd7;
						len_n = '0;
						phase_n = PH_EXTLEN;
					end else begin
						len_n = {57'd0, l7};
						do_check = 1'b1;
					end
				end
				PH_EXTLEN: begin
					len_n = {len_q[55:0], b};
					if (lenleft_q == 3'd0) begin
						do_check = 1'b1;
					end else begin
						lenleft_n = lenleft_q - 3'd1;
					end
				end
				PH_KEY: begin
					key_n = {key_q[23:0], b};
					midx_n = midx_q + 2'd1;
					if (midx_n == 2'd0) begin
						ccode_n = CLOSE_DEFAULT;
						cseen_n = 2'd0;
						if (!fop_q[3] && fop_q != OP_CONT && !fin_q && !inmsg_q) begin
							mop_n = fop_q;
							inmsg_n = 1'b1;
						end
						phase_n = PH_PAYLOAD;
						do_finish = (pleft_q == 64'd0);
					end
				end
				PH_PAYLOAD: begin
					midx_n = midx_q + 2'd1;
					pleft_n = pleft_q - 64'd1;
					last = (pleft_n == 64'd0);
					if (cseen_q == 2'd0) begin
						ccode_n = {pb, 8'h00};
						cseen_n = 2'd1;
					end else if (cseen_q == 2'd1) begin
						ccode_n = {ccode_q[15:8], pb};
						cseen_n = 2'd2;
					end
					// Stray continuation: parse but drop its bytes
					if (!(fop_q == OP_CONT && !inmsg_q)) begin
						a_vld = 1'b1;
						a_rec.kind = KIND_PAYLOAD;
						a_rec.payload_byte = pb;
						if (fop_q == OP_CONT)
							a_rec.message_opcode = mop_q;
						else if (fop_q[3])
							a_rec.message_opcode = fop_q;
						else
							a_rec.message_opcode = (!fin_q && inmsg_q) ? mop_q : fop_q;
						a_rec.frame_opcode = fop_q;
						a_rec.frame_end = last;
						a_rec.message_end = last && fin_q;
					end
					do_finish = last;
				end
				default: begin
					fin_n = b[7];
					fop_n = b[3:0] & HDR_OP_MASK[3:0];
					phase_n = PH_HDR1;
				end
			endcase

			if (do_check) begin
				if (len_n > {32'd0, max_len_q}) begin
					conn_n = CONN_ERROR;
					a_vld = 1'b1;
					a_rec.kind = KIND_OVERSIZE;
				end else begin
					pleft_n = len_n;
					key_n = '0;
					midx_n = '0;
					phase_n = PH_KEY;
				end
			end

			if (do_finish) begin
				phase_n = PH_HDR0;
				if (fop_q == OP_CONT && fin_q && inmsg_n) begin
					inmsg_n = 1'b0;
					mop_n = '0;
				end
				if (fop_q == OP_PING) begin
					b_vld = 1'b1;
					b_rec.kind = KIND_PING;
				end else if (fop_q == OP_PONG) begin
					await_n = 1'b0;
					spong_n = '0;
					b_vld = 1'b1;
					b_rec.kind = KIND_PONG;
				end else if (fop_q == OP_CLOSE) begin
					conn_n = CONN_CLOSED;
					b_vld = 1'b1;
					b_rec.kind = KIND_CLOSE;
					b_rec.close_code = (cseen_n == 2'd2) ? ccode_n : CLOSE_DEFAULT;
				end
			end
		end
	end

	// Pack results: the first valid one leads
	always_comb begin
		push_entry.r0 = a_vld ? a_rec : b_rec;
		push_entry.r1 = b_rec;
		push_entry.two = a_vld && b_vld;
	end
	assign push = fire && (a_vld || b_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			ping_int_q <= PING_INT_RST;
			pong_to_q <= PONG_TOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LEN:   max_len_q <= cfg_data;
				CFG_PING_INT:  ping_int_q <= cfg_data[15:0];
				CFG_PONG_TOUT: pong_to_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			fin_q <= 1'b0;
			fop_q <= '0;
			len_q <= '0;
			lenleft_q <= '0;
			key_q <= '0;
			pleft_q <= '0;
			midx_q <= '0;
			ccode_q <= CLOSE_DEFAULT;
			cseen_q <= '0;
			mop_q <= '0;
			inmsg_q <= 1'b0;
			conn_q <= CONN_OPEN;
			await_q <= 1'b0;
			spong_q <= '0;
			sping_q <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			fin_q <= fin_n;
			fop_q <= fop_n;
			len_q <= len_n;
			lenleft_q <= lenleft_n;
			key_q <= key_n;
			pleft_q <= pleft_n;
			midx_q <= midx_n;
			ccode_q <= ccode_n;
			cseen_q <= cseen_n;
			mop_q <= mop_n;
			inmsg_q <= inmsg_n;
			conn_q <= conn_n;
			await_q <= await_n;
			spong_q <= spong_n;
			sping_q <= sping_n;
		end
	end

endmodule

FILE: rtl/core/wsd_queue.sv
`timescale 1ns / 1ps
module wsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsd_pkg::entry_t push_entry,
	output logic            full,
	output logic            head_valid,
	output wsd_pkg::entry_t head,
	input  logic            pop
);
	import wsd_pkg::*;

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_pop;

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/core/wsd_back.sv
`timescale 1ns / 1ps
module wsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  wsd_pkg::entry_t head,
	output logic            pop,
	wsd_out_if.source       results
);
	import wsd_pkg::*;

	logic idx_q;
	logic out_valid_q;
	rec_t out_rec_q;
	logic out_last_q;
	logic load;
	logic last_of_entry;
	rec_t sel;

	assign load = !out_valid_q || results.ready;
	assign last_of_entry = !head.two || idx_q;
	assign sel = idx_q ? head.r1 : head.r0;
	assign pop = load && head_valid && last_of_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid)
				idx_q <= !last_of_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_rec_q <= sel;
			out_last_q <= last_of_entry;
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind = out_rec_q.kind;
	assign results.payload_byte = out_rec_q.payload_byte;
	assign results.message_opcode = out_rec_q.message_opcode;
	assign results.frame_opcode = out_rec_q.frame_opcode;
	assign results.frame_end = out_rec_q.frame_end;
	assign results.message_end = out_rec_q.message_end;
	assign results.close_code = out_rec_q.close_code;
	assign results.run_last = out_last_q;

endmodule
